>>> src/gamepad_event_qualifier_macros.svh
// ----------------------------------------------------------------------------
// Gamepad event qualifier assertion macros
// Shared property wrappers, clocked on clk and idle while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_EVENT_QUALIFIER_MACROS_SVH
`define GAMEPAD_EVENT_QUALIFIER_MACROS_SVH

// Check that expr holds at every edge outside reset
`define GPQ_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that cons holds at the edge after ante
`define GPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/gpq_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad event qualifier package
// Beat layouts, event codes, thresholds at reset and the hat angle decoder.
// ----------------------------------------------------------------------------
package gpq_pkg;

	typedef enum logic [2:0] {
		ACT_AXIS      = 3'd0,
		ACT_HAT       = 3'd1,
		ACT_BUTTON    = 3'd2,
		ACT_TICK      = 3'd3,
		ACT_TICK_DISC = 3'd4
	} action_t;

	localparam int THR_W  = 11;
	localparam int AXIS_W = 12;
	localparam int CMP_W  = 13;
	localparam int CNT_W  = 8;
	localparam int DIR_W  = 2;
	localparam int HAT_W  = 16;
	localparam int BTN_NUM_W = 5;
	localparam int HELD_W = 32;
	localparam int STICKS = 3;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 80;

	localparam logic [THR_W-1:0] PRESS_RESET   = 11'd563;
	localparam logic [THR_W-1:0] RELEASE_RESET = 11'd460;
	localparam logic [HAT_W-1:0] HAT_CENTRED   = 16'hFFFF;
	localparam logic signed [CMP_W-1:0] AXIS_LIMIT = 13'sd1024;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;
	localparam logic [1:0] HAT_STICK = 2'd2;

	localparam logic signed [DIR_W-1:0] DIR_NEG  = -2'sd1;
	localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sd0;
	localparam logic signed [DIR_W-1:0] DIR_POS  = 2'sd1;

	// Whole-degree bounds expressed in hundredths, so no divide is needed
	localparam int HUND = 100;
	localparam logic [HAT_W-1:0] A45_LO  = 16'(45 * HUND);
	localparam logic [HAT_W-1:0] A45_HI  = 16'(46 * HUND - 1);
	localparam logic [HAT_W-1:0] A135_LO = 16'(135 * HUND);
	localparam logic [HAT_W-1:0] A135_HI = 16'(136 * HUND - 1);
	localparam logic [HAT_W-1:0] A225_LO = 16'(225 * HUND);
	localparam logic [HAT_W-1:0] A225_HI = 16'(226 * HUND - 1);
	localparam logic [HAT_W-1:0] A315_LO = 16'(315 * HUND);
	localparam logic [HAT_W-1:0] A315_HI = 16'(316 * HUND - 1);

	typedef struct packed {
		logic [2:0]                 pad;
		logic                       button_down;
		logic [BTN_NUM_W-1:0]       button_number;
		logic [HAT_W-1:0]           hat_angle;
		logic signed [AXIS_W-1:0]   axis_value;
		logic                       axis_select;
		logic [1:0]                 stick_index;
	} in_beat_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] hat_y;
		logic signed [DIR_W-1:0] hat_x;
		logic [HELD_W-1:0]       buttons_held;
		logic [CNT_W-1:0]        button_count;
		logic [CNT_W-1:0]        count_down;
		logic [CNT_W-1:0]        count_up;
		logic [CNT_W-1:0]        count_right;
		logic [CNT_W-1:0]        count_left;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_x;
	} out_beat_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] x;
		logic signed [DIR_W-1:0] y;
	} hat_dir_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = (c == CNT_MAX) ? c : c + 8'd1;
		return r;
	endfunction

	function automatic hat_dir_t hat_decode(input logic [HAT_W-1:0] a);
		hat_dir_t d;
		d.x = DIR_NONE;
		d.y = DIR_NONE;
		if (a != HAT_CENTRED) begin
			if (a >= A45_LO && a <= A135_HI)
				d.x = DIR_POS;
			else if (a >= A225_LO && a <= A315_HI)
				d.x = DIR_NEG;
			if (a >= A315_LO || a <= A45_HI)
				d.y = DIR_NEG;
			else if (a >= A135_LO && a <= A225_HI)
				d.y = DIR_POS;
		end
		return d;
	endfunction

endpackage

>>> src/gamepad_event_qualifier.sv
// ----------------------------------------------------------------------------
// Gamepad event qualifier
// Turns stick, hat and button events into hysteresis-qualified directions and
// per-frame press counts, one result beat per event beat.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  s_tdata event fields, s_tuser action
// m_*       out        m_tvalid/m_tready  m_tdata result fields
// cfg_*     in         cfg_valid/ready    cfg_index, cfg_data threshold write
//
// One beat per cycle sustained while the output is not stalled; each beat passes the input
// stage, then the update stage that loads the result register and all state together.
// The update stage is one pass of compare and increment logic per event.
// arst_n clears state, counts and both valid flags, and loads the thresholds with their reset values.
// A stalled output holds the result and the input stage; s_tready stays high
// while the result register can drain in the same cycle.
//
module gamepad_event_qualifier #(
	parameter int BUTTONS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// stick_index[1:0], axis_select[2], axis_value[14:3], hat_angle[30:15],
	// button_number[35:31], button_down[36], zero[39:37]
	input  logic [gpq_pkg::IN_TDATA_W-1:0]     s_tdata,
	// action[2:0]
	input  logic [2:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// dir_x[1:0], dir_y[3:2], count_left[11:4], count_right[19:12],
	// count_up[27:20], count_down[35:28], button_count[43:36],
	// buttons_held[75:44], hat_x[77:76], hat_y[79:78]
	output logic [gpq_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [gpq_pkg::THR_W-1:0]          cfg_data
);

	localparam int BTN_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
	localparam logic [5:0] BTN_LIMIT = 6'(BUTTONS);

	localparam logic CFG_PRESS   = 1'b0;
	localparam logic CFG_RELEASE = 1'b1;

	// pipeline control
	logic adv;
	logic fire_s2;
	logic valid_s1;
	gpq_pkg::in_beat_t in_s1;
	gpq_pkg::action_t  act_s1;
	logic out_valid_q;
	gpq_pkg::out_beat_t out_q;

	// state
	logic [gpq_pkg::THR_W-1:0] press_q, release_q;
	logic signed [gpq_pkg::AXIS_W-1:0] pos_q   [0:3];
	logic signed [gpq_pkg::AXIS_W-1:0] pos_nxt [0:3];
	logic signed [gpq_pkg::DIR_W-1:0]  dirx_q   [0:gpq_pkg::STICKS-1];
	logic signed [gpq_pkg::DIR_W-1:0]  dirx_nxt [0:gpq_pkg::STICKS-1];
	logic signed [gpq_pkg::DIR_W-1:0]  diry_q   [0:gpq_pkg::STICKS-1];
	logic signed [gpq_pkg::DIR_W-1:0]  diry_nxt [0:gpq_pkg::STICKS-1];
	logic [gpq_pkg::CNT_W-1:0] cnt_q   [0:gpq_pkg::STICKS-1][0:3];
	logic [gpq_pkg::CNT_W-1:0] cnt_nxt [0:gpq_pkg::STICKS-1][0:3];
	logic [gpq_pkg::CNT_W-1:0] bcnt_q   [0:BUTTONS-1];
	logic [gpq_pkg::CNT_W-1:0] bcnt_nxt [0:BUTTONS-1];
	logic [BUTTONS-1:0] held_q, held_nxt;
	logic [gpq_pkg::HAT_W-1:0] hat_q, hat_nxt;

	// update stage signals
	logic btn_ok;
	logic [BTN_W-1:0] btn_idx;
	logic upd_en;
	logic [1:0] upd_sel;
	logic signed [gpq_pkg::CMP_W-1:0] upd_px, upd_py;
	logic signed [gpq_pkg::CMP_W-1:0] prs, rel;
	logic signed [gpq_pkg::DIR_W-1:0] prx, pry;
	gpq_pkg::hat_dir_t hat_in, hat_out;
	logic [1:0] rep;
	gpq_pkg::out_beat_t res;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || adv;
	assign fire_s2   = valid_s1 && adv;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q   <= gpq_pkg::PRESS_RESET;
			release_q <= gpq_pkg::RELEASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PRESS:   press_q   <= cfg_data;
				CFG_RELEASE: release_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1  <= gpq_pkg::in_beat_t'(s_tdata);
			act_s1 <= gpq_pkg::action_t'(s_tuser);
		end
		if (fire_s2)
			out_q <= res;
	end

	assign btn_ok  = {1'b0, in_s1.button_number} < BTN_LIMIT;
	assign btn_idx = BTN_W'(in_s1.button_number);
	assign prs     = gpq_pkg::CMP_W'($signed({1'b0, press_q}));
	assign rel     = gpq_pkg::CMP_W'($signed({1'b0, release_q}));
	assign hat_in  = gpq_pkg::hat_decode(in_s1.hat_angle);

	always_comb begin
		pos_nxt  = pos_q;
		dirx_nxt = dirx_q;
		diry_nxt = diry_q;
		cnt_nxt  = cnt_q;
		bcnt_nxt = bcnt_q;
		held_nxt = held_q;
		hat_nxt  = hat_q;
		upd_en   = 1'b0;
		upd_sel  = 2'd0;
		upd_px   = '0;
		upd_py   = '0;
		prx      = gpq_pkg::DIR_NONE;
		pry      = gpq_pkg::DIR_NONE;

		unique case (act_s1) inside
			gpq_pkg::ACT_AXIS: begin
				// samples to sticks two and three are dropped
				if (!in_s1.stick_index[1]) begin
					pos_nxt[{in_s1.stick_index[0], in_s1.axis_select}] = in_s1.axis_value;
					upd_en  = 1'b1;
					upd_sel = in_s1.stick_index;
					upd_px  = gpq_pkg::CMP_W'(pos_nxt[{in_s1.stick_index[0], 1'b0}]);
					upd_py  = gpq_pkg::CMP_W'(pos_nxt[{in_s1.stick_index[0], 1'b1}]);
				end
			end
			gpq_pkg::ACT_HAT: begin
				hat_nxt = in_s1.hat_angle;
				upd_en  = 1'b1;
				upd_sel = gpq_pkg::HAT_STICK;
				upd_px  = (hat_in.x == gpq_pkg::DIR_POS) ? gpq_pkg::AXIS_LIMIT :
				          (hat_in.x == gpq_pkg::DIR_NEG) ? -gpq_pkg::AXIS_LIMIT : '0;
				upd_py  = (hat_in.y == gpq_pkg::DIR_POS) ? gpq_pkg::AXIS_LIMIT :
				          (hat_in.y == gpq_pkg::DIR_NEG) ? -gpq_pkg::AXIS_LIMIT : '0;
			end
			gpq_pkg::ACT_BUTTON: begin
				if (btn_ok) begin
					held_nxt[btn_idx] = in_s1.button_down;
					if (in_s1.button_down)
						bcnt_nxt[btn_idx] = gpq_pkg::sat_inc(bcnt_q[btn_idx]);
				end
			end
			gpq_pkg::ACT_TICK, gpq_pkg::ACT_TICK_DISC: begin
				for (int s = 0; s < gpq_pkg::STICKS; s++)
					for (int k = 0; k < 4; k++)
						cnt_nxt[s][k] = '0;
				for (int b = 0; b < BUTTONS; b++)
					bcnt_nxt[b] = '0;
				if (act_s1 == gpq_pkg::ACT_TICK_DISC) begin
					for (int p = 0; p < 4; p++)
						pos_nxt[p] = '0;
					for (int s = 0; s < gpq_pkg::STICKS; s++) begin
						dirx_nxt[s] = gpq_pkg::DIR_NONE;
						diry_nxt[s] = gpq_pkg::DIR_NONE;
					end
					held_nxt = '0;
					hat_nxt  = gpq_pkg::HAT_CENTRED;
				end
			end
			default: ;
		endcase

		// hysteresis: release first, then press against the old direction
		if (upd_en) begin
			prx = dirx_q[upd_sel];
			pry = diry_q[upd_sel];
			if (prx < 0 && upd_px > -rel)
				dirx_nxt[upd_sel] = gpq_pkg::DIR_NONE;
			else if (prx > 0 && upd_px < rel)
				dirx_nxt[upd_sel] = gpq_pkg::DIR_NONE;
			if (pry < 0 && upd_py >= -rel)
				diry_nxt[upd_sel] = gpq_pkg::DIR_NONE;
			else if (pry > 0 && upd_py <= rel)
				diry_nxt[upd_sel] = gpq_pkg::DIR_NONE;
			if (upd_px < -prs && prx >= 0) begin
				dirx_nxt[upd_sel]   = gpq_pkg::DIR_NEG;
				cnt_nxt[upd_sel][0] = gpq_pkg::sat_inc(cnt_q[upd_sel][0]);
			end else if (upd_px > prs && prx <= 0) begin
				dirx_nxt[upd_sel]   = gpq_pkg::DIR_POS;
				cnt_nxt[upd_sel][1] = gpq_pkg::sat_inc(cnt_q[upd_sel][1]);
			end
			if (upd_py < -prs && pry >= 0) begin
				diry_nxt[upd_sel]   = gpq_pkg::DIR_NEG;
				cnt_nxt[upd_sel][2] = gpq_pkg::sat_inc(cnt_q[upd_sel][2]);
			end else if (upd_py > prs && pry <= 0) begin
				diry_nxt[upd_sel]   = gpq_pkg::DIR_POS;
				cnt_nxt[upd_sel][3] = gpq_pkg::sat_inc(cnt_q[upd_sel][3]);
			end
		end
	end

	assign rep     = (act_s1 == gpq_pkg::ACT_HAT) ? gpq_pkg::HAT_STICK : in_s1.stick_index;
	assign hat_out = gpq_pkg::hat_decode(hat_nxt);

	always_comb begin
		res = '0;
		if (rep != 2'd3) begin
			res.dir_x       = dirx_nxt[rep];
			res.dir_y       = diry_nxt[rep];
			res.count_left  = cnt_nxt[rep][0];
			res.count_right = cnt_nxt[rep][1];
			res.count_up    = cnt_nxt[rep][2];
			res.count_down  = cnt_nxt[rep][3];
		end
		if (btn_ok)
			res.button_count = bcnt_nxt[btn_idx];
		res.buttons_held = gpq_pkg::HELD_W'(held_nxt);
		res.hat_x        = hat_out.x;
		res.hat_y        = hat_out.y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < 4; p++)
				pos_q[p] <= '0;
			for (int s = 0; s < gpq_pkg::STICKS; s++) begin
				dirx_q[s] <= gpq_pkg::DIR_NONE;
				diry_q[s] <= gpq_pkg::DIR_NONE;
				for (int k = 0; k < 4; k++)
					cnt_q[s][k] <= '0;
			end
			for (int b = 0; b < BUTTONS; b++)
				bcnt_q[b] <= '0;
			held_q <= '0;
			hat_q  <= gpq_pkg::HAT_CENTRED;
		end else if (fire_s2) begin
			pos_q  <= pos_nxt;
			dirx_q <= dirx_nxt;
			diry_q <= diry_nxt;
			cnt_q  <= cnt_nxt;
			bcnt_q <= bcnt_nxt;
			held_q <= held_nxt;
			hat_q  <= hat_nxt;
		end
	end

`include "gamepad_event_qualifier_macros.svh"

	`GPQ_ASSERT_ALWAYS(a_dir_legal, !m_tvalid || (out_q.dir_x != 2'b10 && out_q.dir_y != 2'b10), "reported direction out of range")
	`GPQ_ASSERT_ALWAYS(a_hat_legal, !m_tvalid || (out_q.hat_x != 2'b10 && out_q.hat_y != 2'b10), "hat direction out of range")
	`GPQ_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1, "input stage lost a beat while stalled")
	`GPQ_ASSERT_NEXT(a_disc_clear, fire_s2 && act_s1 == gpq_pkg::ACT_TICK_DISC, held_q == '0 && hat_q == gpq_pkg::HAT_CENTRED, "disconnect tick left state behind")

endmodule
